@@ hw/rtl/wireworld_generation_step_top_assert.svh @@
// Assertion macros used by the board step top level.
`ifndef WIREWORLD_GENERATION_STEP_TOP_ASSERT_SVH
`define WIREWORLD_GENERATION_STEP_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wws_pkg.sv @@
// Shared types, codes and the per-cell update rule for the board step block.
`timescale 1ns / 1ps
`default_nettype none

package wws_pkg;

  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 64;

  localparam int KIND_W = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int CELL_W = 2;
  // wide enough to hold any board dimension up to 511
  localparam int DIM_W  = 9;
  localparam int ROW_PAD = DIM_W - ROW_W;
  localparam int COL_PAD = DIM_W - COL_W;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [CELL_W-1:0] CELL_HEAD  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_TAIL  = 2'd2;
  localparam logic [CELL_W-1:0] CELL_WIRE  = 2'd3;

  // command to one row cell for the item being accepted
  typedef struct packed {
    logic              ld;     // item accepted: capture addressed cell
    logic              wr;     // write this row
    logic              step;   // advance one generation
    logic [CELL_W-1:0] wdata;
  } wws_cmd_t;

  // next code of one cell given the head flags of its eight neighbours
  function automatic logic [CELL_W-1:0] cell_next(input logic [CELL_W-1:0] cur,
                                                  input logic [7:0] nb);
    logic [3:0]        cnt;
    logic [CELL_W-1:0] res;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'b000, nb[i]};
    end
    case (cur)
      CELL_HEAD: res = CELL_TAIL;
      CELL_TAIL: res = CELL_WIRE;
      CELL_WIRE: res = (cnt == 4'd1 || cnt == 4'd2) ? CELL_HEAD : CELL_WIRE;
      default:   res = CELL_EMPTY;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wws_row_cell.sv @@
// One board row: holds its cells, trades head flags with the rows either side.
`timescale 1ns / 1ps
`default_nettype none

module wws_row_cell
  import wws_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wws_cmd_t          cmd,
  input  wire logic [CIDX_W-1:0] col_sel,
  input  wire logic [COLS-1:0]   up_heads,
  input  wire logic [COLS-1:0]   dn_heads,
  output      logic [COLS-1:0]   heads,
  output      logic [CELL_W-1:0] rd_val
);

  logic [CELL_W-1:0] cells      [COLS];
  logic [CELL_W-1:0] cells_next [COLS];

  // head flags padded with a non-head on each side of the row
  logic [COLS+1:0] up_p, mid_p, dn_p;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      heads[c] = (cells[c] == CELL_HEAD);
    end
  end

  assign up_p  = {1'b0, up_heads, 1'b0};
  assign mid_p = {1'b0, heads, 1'b0};
  assign dn_p  = {1'b0, dn_heads, 1'b0};

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      cells_next[c] = cell_next(cells[c],
                                {up_p[c], up_p[c+1], up_p[c+2],
                                 mid_p[c], mid_p[c+2],
                                 dn_p[c], dn_p[c+1], dn_p[c+2]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLS; c++) begin
        cells[c] <= CELL_EMPTY;
      end
    end else if (cmd.step) begin
      for (int c = 0; c < COLS; c++) begin
        cells[c] <= cells_next[c];
      end
    end else if (cmd.wr) begin
      cells[col_sel] <= cmd.wdata;
    end
  end

  // old value of the addressed column, taken before any write lands
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      rd_val <= cells[col_sel];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wireworld_generation_step_top.sv @@
// Top level of the Wireworld board: command port, row cell chain, result register.
//
//   channel   dir  ports                                       handshake
//   --------  ---  ------------------------------------------  ---------------------
//   command   in   kind, row_index, col_index, cell_in         start & !busy
//   result    out  cell_out, done_kind                         done, one cycle, no stall
//
// Flow: the accepting edge writes the cell or advances every row at once, and
// captures the addressed cell in each row; the next edge picks the addressed
// row's capture into the result register. done is high in the cycle after that,
// and busy is high only for the one cycle in between, so a new item can be
// accepted while the previous result is on the ports.
// Reset: rst clears the whole board to empty (each cell is a flop) and drops
// busy and done.
// Stalls: none on the result side; the receiver must take done when it comes.
`timescale 1ns / 1ps
`default_nettype none
`include "wireworld_generation_step_top_assert.svh"

module wireworld_generation_step_top
  import wws_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ROW_W-1:0]  row_index,
  input  wire logic [COL_W-1:0]  col_index,
  input  wire logic [CELL_W-1:0] cell_in,
  output      logic              done,
  output      logic [CELL_W-1:0] cell_out,
  output      logic [KIND_W-1:0] done_kind
);

  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  logic             accept;
  logic [DIM_W-1:0] row_x, col_x;
  logic             on_board;

  // pending item between accept and result
  logic              pend;
  logic [RIDX_W-1:0] row_q;
  logic              hit_q;     // read or write that landed on the board
  logic [KIND_W-1:0] kind_q;

  logic [CELL_W-1:0] rd_val [ROWS];
  // head flags per row, with an all-clear row above the first and below the last
  logic [COLS-1:0]   heads_a [ROWS+2];

  assign accept   = start && !busy;
  assign busy     = pend;
  assign row_x    = {{ROW_PAD{1'b0}}, row_index};
  assign col_x    = {{COL_PAD{1'b0}}, col_index};
  assign on_board = (row_x < DIM_W'(ROWS)) && (col_x < DIM_W'(COLS));

  assign heads_a[0]      = '0;
  assign heads_a[ROWS+1] = '0;

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    wws_cmd_t cmd;
    always_comb begin
      cmd.ld    = accept;
      cmd.wr    = accept && on_board && (kind == KIND_WRITE) && (row_x == DIM_W'(r));
      cmd.step  = accept && (kind == KIND_STEP);
      cmd.wdata = cell_in;
    end

    wws_row_cell #(
      .COLS(COLS)
    ) u_row (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .col_sel (col_x[CIDX_W-1:0]),
      .up_heads(heads_a[r]),
      .dn_heads(heads_a[r+2]),
      .heads   (heads_a[r+1]),
      .rd_val  (rd_val[r])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= accept;
      done <= pend;
    end
  end

  // item fields held for the result stage
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q  <= row_x[RIDX_W-1:0];
      hit_q  <= on_board && (kind == KIND_WRITE || kind == KIND_READ);
      kind_q <= kind;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pend) begin
      cell_out  <= hit_q ? rd_val[row_q] : CELL_EMPTY;
      done_kind <= kind_q;
    end
  end

  `WWS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted item did not raise busy")
  `WWS_ASSERT_NEXT(a_busy_done, clk, rst, busy, done, "pending item gave no result")
  `WWS_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result shown while another item pending")
  `WWS_ASSERT_NOW(a_step_zero, clk, rst, done && (done_kind == KIND_STEP || done_kind == KIND_UNUSED), cell_out == CELL_EMPTY, "step or unused kind returned a cell")

endmodule

`default_nettype wire

@@ tb/wireworld_generation_step_checker.sv @@
// Board predictor and result checker for the Wireworld generation step block.
`timescale 1ns / 1ps

module wireworld_generation_step_checker
  import wws_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ROW_W-1:0]  row_index,
  input  wire logic [COL_W-1:0]  col_index,
  input  wire logic [CELL_W-1:0] cell_in,
  input  wire logic              done,
  input  wire logic [CELL_W-1:0] cell_out,
  input  wire logic [KIND_W-1:0] done_kind,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [KIND_W-1:0] kind_val;
  } board_result_t;

  board_result_t     expected_q[$];
  board_result_t     want;
  logic [CELL_W-1:0] board      [ROWS][COLS];
  logic [CELL_W-1:0] next_board [ROWS][COLS];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // heads among the eight neighbours; off-board positions are never heads
  function automatic int heads_around(input int r, input int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
            c + dc >= 0 && c + dc < COLS) begin
          if (board[r+dr][c+dc] == CELL_HEAD) n++;
        end
      end
    end
    return n;
  endfunction

  task automatic advance_board();
    int h;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        case (board[r][c])
          CELL_HEAD: next_board[r][c] = CELL_TAIL;
          CELL_TAIL: next_board[r][c] = CELL_WIRE;
          CELL_WIRE: begin
            h = heads_around(r, c);
            next_board[r][c] = (h == 1 || h == 2) ? CELL_HEAD : CELL_WIRE;
          end
          default:   next_board[r][c] = CELL_EMPTY;
        endcase
      end
    end
    board = next_board;
  endtask

  task automatic predict_item(input logic [KIND_W-1:0] k, input logic [ROW_W-1:0] r,
                              input logic [COL_W-1:0] c, input logic [CELL_W-1:0] v);
    board_result_t res;
    logic          on_board;
    res.kind_val = k;
    res.cell_val = CELL_EMPTY;
    on_board = (int'(r) < ROWS) && (int'(c) < COLS);
    case (k)
      KIND_WRITE: begin
        if (on_board) begin
          res.cell_val = board[r][c];
          board[r][c] = v;
        end
      end
      KIND_STEP: advance_board();
      KIND_READ: begin
        if (on_board) res.cell_val = board[r][c];
      end
      default: ;
    endcase
    expected_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          board[r][c] = CELL_EMPTY;
        end
      end
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: cell_out %0d done_kind %0d",
                                    cell_out, done_kind));
        end else begin
          want = expected_q.pop_front();
          if (cell_out !== want.cell_val) begin
            report_mismatch($sformatf("cell_out %0d, expected %0d (kind %0d)",
                                      cell_out, want.cell_val, want.kind_val));
          end
          if (done_kind !== want.kind_val) begin
            report_mismatch($sformatf("done_kind %0d, expected %0d",
                                      done_kind, want.kind_val));
          end
        end
      end
      if (start && !busy) predict_item(kind, row_index, col_index, cell_in);
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ tb/wireworld_generation_step_top_test.sv @@
// Top of the Wireworld board regression: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module wireworld_generation_step_top_test;
  import wws_pkg::*;

  // generous: well above the slowest correct run
  localparam int CYCLE_LIMIT  = 100000;
  localparam int PHASE_ITEMS  = 200;
  localparam int SETTLE_TICKS = 8;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic [KIND_W-1:0] kind      = KIND_WRITE;
  logic [ROW_W-1:0]  row_index = '0;
  logic [COL_W-1:0]  col_index = '0;
  logic [CELL_W-1:0] cell_in   = CELL_EMPTY;
  logic              busy;
  logic              done;
  logic [CELL_W-1:0] cell_out;
  logic [KIND_W-1:0] done_kind;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  int idle_pct    = 0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wireworld_generation_step_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .row_index (row_index),
    .col_index (col_index),
    .cell_in   (cell_in),
    .done      (done),
    .cell_out  (cell_out),
    .done_kind (done_kind)
  );

  wireworld_generation_step_checker board_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .row_index   (row_index),
    .col_index   (col_index),
    .cell_in     (cell_in),
    .done        (done),
    .cell_out    (cell_out),
    .done_kind   (done_kind),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one item and return at the edge that accepts it. start is left high
  // so that a following item can go straight out; an idle gap lowers it first.
  // busy read straight after the edge is its value before that edge, which is
  // exactly what the block sampled. Row and column arrive as plain integers
  // and are cut to the port widths here.
  task automatic send_item(input logic [KIND_W-1:0] k, input int r,
                           input int c, input logic [CELL_W-1:0] v);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start     <= 1'b1;
    kind      <= k;
    row_index <= ROW_W'(r);
    col_index <= COL_W'(c);
    cell_in   <= v;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Hold off until every item in flight has produced its result. The count
  // from the checker is registered, so it is first read only after the last
  // acceptance and already includes that item.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // mostly conductor, so that signals have somewhere to run
  function automatic logic [CELL_W-1:0] wire_cell();
    int p;
    p = $urandom_range(99);
    if (p < 60) return CELL_WIRE;
    if (p < 80) return CELL_HEAD;
    if (p < 90) return CELL_TAIL;
    return CELL_EMPTY;
  endfunction

  // Edges, corners and neighbour counts of one, two and three heads.
  task automatic run_directed();
    send_item(KIND_READ,  0,  0,  CELL_WIRE);   // fresh board reads empty
    send_item(KIND_WRITE, 0,  0,  CELL_WIRE);
    send_item(KIND_WRITE, 0,  1,  CELL_HEAD);   // corner wire, one head
    send_item(KIND_WRITE, 31, 63, CELL_WIRE);
    send_item(KIND_WRITE, 30, 62, CELL_HEAD);
    send_item(KIND_WRITE, 31, 62, CELL_HEAD);   // far corner, two heads
    send_item(KIND_WRITE, 15, 30, CELL_WIRE);
    send_item(KIND_WRITE, 14, 29, CELL_HEAD);
    send_item(KIND_WRITE, 14, 30, CELL_HEAD);
    send_item(KIND_WRITE, 14, 31, CELL_HEAD);   // three heads: stays conductor
    send_item(KIND_WRITE, 20, 20, CELL_TAIL);
    send_item(KIND_WRITE, 20, 20, CELL_TAIL);   // prior code returned
    send_item(KIND_STEP,  31, 63, CELL_WIRE);   // unused fields all ones
    send_item(KIND_READ,  0,  0,  CELL_EMPTY);
    send_item(KIND_READ,  0,  1,  CELL_WIRE);   // cell_in ignored by a read
    send_item(KIND_READ,  31, 63, CELL_EMPTY);
    send_item(KIND_READ,  15, 30, CELL_EMPTY);
    send_item(KIND_READ,  20, 20, CELL_EMPTY);
    send_item(KIND_READ,  14, 30, CELL_EMPTY);
    send_item(KIND_UNUSED, 31, 63, CELL_WIRE);  // unused kind: no effect
    send_item(KIND_UNUSED, 0,  0,  CELL_EMPTY);
    send_item(KIND_WRITE, 0,  1,  CELL_EMPTY);
    send_item(KIND_STEP,  0,  0,  CELL_EMPTY);
    send_item(KIND_READ,  0,  1,  CELL_EMPTY);
    send_item(KIND_READ,  0,  0,  CELL_EMPTY);
  endtask

  // One random scene: lay a strand of wire with a few heads, maybe a second
  // strand beside it, then run some generations and read around the spot.
  task automatic random_scene();
    int base_r;
    int base_c;
    int len;
    int rounds;
    int side_r;
    base_r = $urandom_range(0, ROWS_DEF - 1);
    base_c = $urandom_range(0, COLS_DEF - 1);
    len    = $urandom_range(3, 12);
    for (int i = 0; i < len; i++) begin
      send_item(KIND_WRITE, base_r, clamp(base_c + i, COLS_DEF - 1), wire_cell());
    end
    if ($urandom_range(1)) begin
      side_r = clamp(base_r + ($urandom_range(1) ? 1 : -1), ROWS_DEF - 1);
      for (int i = 0; i < len; i += $urandom_range(1, 2)) begin
        send_item(KIND_WRITE, side_r, clamp(base_c + i, COLS_DEF - 1), wire_cell());
      end
    end
    rounds = $urandom_range(2, 8);
    for (int i = 0; i < rounds; i++) begin
      send_item(KIND_STEP, $urandom, $urandom, CELL_W'($urandom));
      repeat ($urandom_range(1, 3)) begin
        send_item(KIND_READ, clamp(base_r + $urandom_range(0, 2) - 1, ROWS_DEF - 1),
                  clamp(base_c + $urandom_range(0, len), COLS_DEF - 1),
                  CELL_W'($urandom));
      end
    end
    // noise: unused kind or a stray access anywhere on the board
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(2))
        0:       send_item(KIND_UNUSED, $urandom, $urandom, CELL_W'($urandom));
        1:       send_item(KIND_WRITE, $urandom, $urandom, CELL_W'($urandom));
        default: send_item(KIND_READ, $urandom, $urandom, CELL_W'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    // sender holds off until the board is quiet
    wait_for_drain();

    // three random phases: light sender gaps, heavy gaps, back to back
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 15;
        1:       idle_pct = 66;
        default: idle_pct = 0;
      endcase
      while (items_sent < 25 + (phase + 1) * PHASE_ITEMS) random_scene();
      wait_for_drain();
    end

    // let any late or stray result show up before the verdict
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/wws_pkg.sv
hw/rtl/wws_row_cell.sv
hw/rtl/wireworld_generation_step_top.sv
tb/wireworld_generation_step_checker.sv
tb/wireworld_generation_step_top_test.sv
